/* src/lipe_pkg.sv */
// shared constants for the indicator led pattern engine
package lipe_pkg;

  localparam int unsigned NumLeds   = 4;
  localparam int unsigned ModeW     = 3;
  localparam int unsigned TargetW   = 3;
  localparam int unsigned PeriodW   = 8;
  localparam int unsigned BlinkW    = 3;
  localparam int unsigned PulseW    = 6;
  localparam int unsigned StepW     = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 8;

  // led slots
  localparam int unsigned LedGreen  = 0;
  localparam int unsigned LedYellow = 1;
  localparam int unsigned LedBlue   = 2;
  localparam int unsigned LedStatus = 3;

  // operation codes
  localparam logic OpTick    = 1'b0;
  localparam logic OpCommand = 1'b1;

  // command targets
  localparam logic [TargetW-1:0] TgtNone      = 3'd0;
  localparam logic [TargetW-1:0] TgtGreen     = 3'd1;
  localparam logic [TargetW-1:0] TgtYellow    = 3'd2;
  localparam logic [TargetW-1:0] TgtBlue      = 3'd3;
  localparam logic [TargetW-1:0] TgtStatus    = 3'd4;
  localparam logic [TargetW-1:0] TgtAll       = 3'd5;
  localparam logic [TargetW-1:0] TgtAllButSts = 3'd6;

  // led modes; code seven is stored and acts like hold
  localparam logic [ModeW-1:0] ModeHold   = 3'd0;
  localparam logic [ModeW-1:0] ModeBlink  = 3'd1;
  localparam logic [ModeW-1:0] ModeFlash  = 3'd2;
  localparam logic [ModeW-1:0] ModeDouble = 3'd3;
  localparam logic [ModeW-1:0] ModeWarn   = 3'd4;
  localparam logic [ModeW-1:0] ModeSolid  = 3'd5;
  localparam logic [ModeW-1:0] ModeOff    = 3'd6;

  localparam logic [StepW-1:0] StepIdle  = 3'd0;
  localparam logic [StepW-1:0] StepFirst = 3'd1;
  localparam logic [StepW-1:0] StepThird = 3'd3;
  localparam logic [StepW-1:0] StepLast  = 3'd7;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPeriodTicks  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBlinkPeriods = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPulseTicks   = 2'd2;

  // register reset values
  localparam logic [PeriodW-1:0] PeriodTicksRst  = 8'd50;
  localparam logic [BlinkW-1:0]  BlinkPeriodsRst = 3'd5;
  localparam logic [PulseW-1:0]  PulseTicksRst   = 6'd5;

  typedef logic [ModeW-1:0] mode_t;

endpackage

/* src/led_indicator_pattern_engine.sv */
// indicator led pattern engine: mode registers, tick counters and led levels
// an accepted item's led levels are registered and shown on the outputs in the next cycle
// throughput: one item per cycle while out_ready_i takes each result; the only loop is the state register update
// an item is taken while a finished result is being taken in the same cycle
// reset (rst_ni low, asynchronous) sets all modes to hold, all leds off,
// all counters to zero and the registers to 50, 5 and 5 ticks/periods
module led_indicator_pattern_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [lipe_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lipe_pkg::CfgDataW-1:0] cfg_data_i,
  // item channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [lipe_pkg::TargetW-1:0]  target_i,
  input  logic [lipe_pkg::ModeW-1:0]    mode_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          green_on_o,
  output logic                          yellow_on_o,
  output logic                          blue_on_o,
  output logic                          status_on_o
);
  import lipe_pkg::*;

  // configuration registers
  logic [PeriodW-1:0] period_ticks_q;
  logic [BlinkW-1:0]  blink_periods_q;
  logic [PulseW-1:0]  pulse_ticks_q;

  // engine state
  mode_t              mode_q [NumLeds];
  mode_t              mode_d [NumLeds];
  logic [NumLeds-1:0] led_q, led_d;
  logic [PeriodW-1:0] fine_q, fine_d;
  logic [BlinkW-1:0]  period_cnt_q, period_cnt_d;
  logic [StepW-1:0]   step_q, step_d;
  logic [PulseW-1:0]  burst_cnt_q, burst_cnt_d;
  logic               out_valid_q;

  logic               in_xfer;
  logic [PeriodW:0]   fine_inc;
  logic [PulseW:0]    burst_inc;
  logic [BlinkW-1:0]  period_inc;
  logic               period_start;
  logic               blink_now;
  logic               step_change;
  logic               dbl_lvl;
  logic               wrn_lvl;
  logic [NumLeds-1:0] tgt_sel;

  // the result register frees up when its transfer completes
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_ticks_q  <= PeriodTicksRst;
      blink_periods_q <= BlinkPeriodsRst;
      pulse_ticks_q   <= PulseTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPeriodTicks:  period_ticks_q  <= cfg_data_i[PeriodW-1:0];
        CfgBlinkPeriods: blink_periods_q <= cfg_data_i[BlinkW-1:0];
        CfgPulseTicks:   pulse_ticks_q   <= cfg_data_i[PulseW-1:0];
        default: ;
      endcase
    end
  end

  // counter arithmetic; a zero register compares like one
  assign fine_inc     = {1'b0, fine_q} + 1'b1;
  assign period_start = fine_inc >= {1'b0, period_ticks_q};
  assign period_inc   = period_cnt_q + 1'b1;
  assign blink_now    = period_inc >= blink_periods_q;
  assign burst_inc    = {1'b0, burst_cnt_q} + 1'b1;
  assign step_change  = (step_q != StepIdle) && (burst_inc >= {1'b0, pulse_ticks_q});

  // which leds a command reaches
  always_comb begin
    tgt_sel = '0;
    unique case (target_i)
      TgtGreen:     tgt_sel[LedGreen]  = 1'b1;
      TgtYellow:    tgt_sel[LedYellow] = 1'b1;
      TgtBlue:      tgt_sel[LedBlue]   = 1'b1;
      TgtStatus:    tgt_sel[LedStatus] = 1'b1;
      TgtAll:       tgt_sel = '1;
      TgtAllButSts: begin
        tgt_sel[LedGreen]  = 1'b1;
        tgt_sel[LedYellow] = 1'b1;
        tgt_sel[LedBlue]   = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    mode_d       = mode_q;
    led_d        = led_q;
    fine_d       = fine_q;
    period_cnt_d = period_cnt_q;
    step_d       = step_q;
    burst_cnt_d  = burst_cnt_q;
    dbl_lvl      = 1'b0;
    wrn_lvl      = 1'b0;
    if (op_i == OpTick) begin
      if (period_start) begin
        fine_d       = '0;
        period_cnt_d = blink_now ? '0 : period_inc;
        step_d       = StepFirst;
        burst_cnt_d  = '0;
      end else begin
        fine_d = fine_inc[PeriodW-1:0];
        if (step_q != StepIdle) begin
          if (step_change) begin
            burst_cnt_d = '0;
            step_d      = (step_q == StepLast) ? StepIdle : step_q + 1'b1;
          end else begin
            burst_cnt_d = burst_inc[PulseW-1:0];
          end
        end
      end
      // burst levels follow the new step
      dbl_lvl = (step_d == StepFirst) || (step_d == StepThird);
      wrn_lvl = step_d[0];
      for (int i = 0; i < NumLeds; i++) begin
        if (period_start && (mode_q[i] == ModeFlash ||
                             (blink_now && mode_q[i] == ModeBlink))) begin
          led_d[i] = !led_q[i];
        end
        if (period_start || step_change) begin
          if (mode_q[i] == ModeDouble) begin
            led_d[i] = dbl_lvl;
          end else if (mode_q[i] == ModeWarn) begin
            led_d[i] = wrn_lvl;
          end
        end
      end
    end else begin
      // solid and off act at once, other modes keep the level
      for (int i = 0; i < NumLeds; i++) begin
        if (tgt_sel[i]) begin
          mode_d[i] = mode_i;
          if (mode_i == ModeSolid) begin
            led_d[i] = 1'b1;
          end else if (mode_i == ModeOff) begin
            led_d[i] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLeds; i++) begin
        mode_q[i] <= ModeHold;
      end
      led_q        <= '0;
      fine_q       <= '0;
      period_cnt_q <= '0;
      step_q       <= StepIdle;
      burst_cnt_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_xfer) begin
        mode_q       <= mode_d;
        led_q        <= led_d;
        fine_q       <= fine_d;
        period_cnt_q <= period_cnt_d;
        step_q       <= step_d;
        burst_cnt_q  <= burst_cnt_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // levels only change on an accepted item, so they double as the result
  assign out_valid_o = out_valid_q;
  assign green_on_o  = led_q[LedGreen];
  assign yellow_on_o = led_q[LedYellow];
  assign blue_on_o   = led_q[LedBlue];
  assign status_on_o = led_q[LedStatus];

  // burst counter only runs during a burst
  a_burst_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (burst_cnt_q != '0) |-> (step_q != StepIdle))
    else $error("burst tick count nonzero while burst idle");

  // commands never move the time base
  a_cmd_keeps_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && op_i == OpCommand) |=> ($stable(fine_q) && $stable(step_q) &&
                                        $stable(period_cnt_q)))
    else $error("command advanced a counter");

  // solid to all lights every led in the next result
  a_solid_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && op_i == OpCommand && target_i == TgtAll && mode_i == ModeSolid)
    |=> (out_valid_o && led_q == '1))
    else $error("solid command to all did not light every led");

  // a result appears only after an item transfer
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_xfer))
    else $error("result without an accepted item");

endmodule
